// ----- rtl/kct_pkg.sv -----
// Package for the keypad countdown timer: request and result types, mode, key,
// opcode and register index codes, and the keypad lookup table.
// No dependencies.
package kct_pkg;

  localparam int KeypadSize = 4;
  localparam int KeyW       = $clog2(KeypadSize);
  localparam int CntW       = 10;
  localparam int DigitW     = 4;
  localparam int CfgIdxW    = 1;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [1:0] MODE_INPUT = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_ALARM = 2'd3;

  localparam logic [DigitW-1:0] K_A    = 4'd10;
  localparam logic [DigitW-1:0] K_B    = 4'd11;
  localparam logic [DigitW-1:0] K_C    = 4'd12;
  localparam logic [DigitW-1:0] K_D    = 4'd13;
  localparam logic [DigitW-1:0] K_STAR = 4'd14;
  localparam logic [DigitW-1:0] K_HASH = 4'd15;

  localparam logic [DigitW-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DigitW-1:0] TENS_MAX  = 4'd5;

  localparam logic [CfgIdxW-1:0] CFG_LOCKOUT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_TPS     = 1'd1;

  localparam logic [CntW-1:0] LOCKOUT_RESET = 10'd100;
  localparam logic [CntW-1:0] TPS_RESET     = 10'd1000;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [KeyW-1:0] key_column;
    logic [KeyW-1:0] key_row;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        timer_mode;
    logic [DigitW-1:0] entry_minutes;
    logic [DigitW-1:0] entry_tens;
    logic [DigitW-1:0] entry_units;
    logic [DigitW-1:0] remain_minutes;
    logic [DigitW-1:0] remain_tens;
    logic [DigitW-1:0] remain_units;
    logic              key_led;
    logic              alarm_led;
    logic              refresh;
  } out_res_t;

  typedef struct packed {
    logic [CntW-1:0] lockout_ticks;
    logic [CntW-1:0] ticks_per_second;
  } cfg_regs_t;

  function automatic logic [DigitW-1:0] key_lookup(input logic [KeyW-1:0] col,
                                                   input logic [KeyW-1:0] row);
    logic [DigitW-1:0] k;
    unique case ({col, row})
      4'h0: k = K_D;
      4'h1: k = K_C;
      4'h2: k = K_B;
      4'h3: k = K_A;
      4'h4: k = K_HASH;
      4'h5: k = 4'd9;
      4'h6: k = 4'd6;
      4'h7: k = 4'd3;
      4'h8: k = 4'd0;
      4'h9: k = 4'd8;
      4'hA: k = 4'd5;
      4'hB: k = 4'd2;
      4'hC: k = K_STAR;
      4'hD: k = 4'd7;
      4'hE: k = 4'd4;
      default: k = 4'd1;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/kct_in_reg.sv -----
// Input register stage of the keypad countdown timer.
// Holds one accepted request until the engine takes it; uses kct_pkg.
module kct_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  kct_pkg::in_req_t in_req,
  output logic            in_stall,
  input  logic            advance,
  output logic            s1_valid,
  output kct_pkg::in_req_t s1_req
);

  logic             valid_r;
  logic             valid_nxt;
  kct_pkg::in_req_t req_r;
  logic             take;

  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take || (valid_r && !advance);
  assign s1_valid  = valid_r;
  assign s1_req    = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_req;
    end
  end

endmodule

// ----- rtl/kct_engine.sv -----
// Timer state and its combinational update for one request.
// Produces the result for the request being processed; uses kct_pkg.
module kct_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  kct_pkg::in_req_t    req,
  input  kct_pkg::cfg_regs_t  cfg,
  output kct_pkg::out_res_t   result
);

  localparam int DW = kct_pkg::DigitW;
  localparam int CW = kct_pkg::CntW;

  logic [1:0]    mode_r,     mode_nxt;
  logic [DW-1:0] ent_m_r,    ent_m_nxt;
  logic [DW-1:0] ent_t_r,    ent_t_nxt;
  logic [DW-1:0] ent_u_r,    ent_u_nxt;
  logic [DW-1:0] rem_m_r,    rem_m_nxt;
  logic [DW-1:0] rem_t_r,    rem_t_nxt;
  logic [DW-1:0] rem_u_r,    rem_u_nxt;
  logic [CW-1:0] lock_r,     lock_nxt;
  logic          held_r,     held_nxt;
  logic [DW-1:0] hkey_r,     hkey_nxt;
  logic [CW-1:0] phase_r,    phase_nxt;
  logic          refresh;
  logic [DW-1:0] key;
  logic [CW:0]   phase_inc;
  logic          do_start;

  assign key       = kct_pkg::key_lookup(req.key_column, req.key_row);
  assign phase_inc = {1'b0, phase_r} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    mode_nxt  = mode_r;
    ent_m_nxt = ent_m_r;
    ent_t_nxt = ent_t_r;
    ent_u_nxt = ent_u_r;
    rem_m_nxt = rem_m_r;
    rem_t_nxt = rem_t_r;
    rem_u_nxt = rem_u_r;
    lock_nxt  = lock_r;
    held_nxt  = held_r;
    hkey_nxt  = hkey_r;
    phase_nxt = phase_r;
    refresh   = 1'b0;
    do_start  = 1'b0;
    unique case (req.opcode)
      kct_pkg::OP_PRESS: begin
        if (lock_r == '0 && !held_r) begin
          held_nxt = 1'b1;
          hkey_nxt = key;
          lock_nxt = cfg.lockout_ticks;
          refresh  = 1'b1;
          unique case (mode_r)
            kct_pkg::MODE_INPUT: begin
              if (key <= kct_pkg::DIGIT_MAX) begin
                ent_m_nxt = ent_t_r;
                ent_t_nxt = ent_u_r;
                ent_u_nxt = key;
                if (ent_t_r == kct_pkg::DIGIT_MAX && ent_u_r > kct_pkg::TENS_MAX) begin
                  ent_t_nxt = kct_pkg::TENS_MAX;
                  ent_u_nxt = kct_pkg::DIGIT_MAX;
                end
              end else if (key == kct_pkg::K_A) begin
                do_start = 1'b1;
              end
            end
            kct_pkg::MODE_COUNT: begin
              if (key == kct_pkg::K_B) begin
                mode_nxt = kct_pkg::MODE_STOP;
              end
            end
            kct_pkg::MODE_STOP: begin
              if (key == kct_pkg::K_A) begin
                do_start = 1'b1;
              end else if (key == kct_pkg::K_D) begin
                mode_nxt = kct_pkg::MODE_INPUT;
              end
            end
            default: begin
              if (key == kct_pkg::K_A) begin
                do_start = 1'b1;
              end else if (key == kct_pkg::K_B) begin
                mode_nxt = kct_pkg::MODE_STOP;
              end else if (key == kct_pkg::K_D) begin
                mode_nxt = kct_pkg::MODE_INPUT;
              end
            end
          endcase
          if (do_start) begin
            mode_nxt  = kct_pkg::MODE_COUNT;
            rem_m_nxt = ent_m_r;
            rem_t_nxt = ent_t_r;
            rem_u_nxt = ent_u_r;
            phase_nxt = '0;
          end
        end
      end
      kct_pkg::OP_RELEASE: begin
        if (held_r && hkey_r == key) begin
          held_nxt = 1'b0;
          hkey_nxt = '0;
        end
      end
      kct_pkg::OP_TICK: begin
        if (lock_r != '0) begin
          lock_nxt = lock_r - {{(CW-1){1'b0}}, 1'b1};
        end
        if (mode_r == kct_pkg::MODE_COUNT) begin
          if (phase_inc >= {1'b0, cfg.ticks_per_second}) begin
            phase_nxt = '0;
            refresh   = 1'b1;
            if (rem_u_r != '0) begin
              rem_u_nxt = rem_u_r - {{(DW-1){1'b0}}, 1'b1};
            end else if (rem_t_r != '0) begin
              rem_t_nxt = rem_t_r - {{(DW-1){1'b0}}, 1'b1};
              rem_u_nxt = kct_pkg::DIGIT_MAX;
            end else if (rem_m_r != '0) begin
              rem_m_nxt = rem_m_r - {{(DW-1){1'b0}}, 1'b1};
              rem_t_nxt = kct_pkg::TENS_MAX;
              rem_u_nxt = kct_pkg::DIGIT_MAX;
            end else begin
              mode_nxt = kct_pkg::MODE_ALARM;
            end
          end else begin
            phase_nxt = phase_inc[CW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.timer_mode     = mode_nxt;
    result.entry_minutes  = ent_m_nxt;
    result.entry_tens     = ent_t_nxt;
    result.entry_units    = ent_u_nxt;
    result.remain_minutes = rem_m_nxt;
    result.remain_tens    = rem_t_nxt;
    result.remain_units   = rem_u_nxt;
    result.key_led        = held_nxt;
    result.alarm_led      = (mode_nxt == kct_pkg::MODE_ALARM);
    result.refresh        = refresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= kct_pkg::MODE_INPUT;
      ent_m_r <= '0;
      ent_t_r <= '0;
      ent_u_r <= '0;
      rem_m_r <= '0;
      rem_t_r <= '0;
      rem_u_r <= '0;
      lock_r  <= '0;
      held_r  <= 1'b0;
      hkey_r  <= '0;
      phase_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      ent_m_r <= ent_m_nxt;
      ent_t_r <= ent_t_nxt;
      ent_u_r <= ent_u_nxt;
      rem_m_r <= rem_m_nxt;
      rem_t_r <= rem_t_nxt;
      rem_u_r <= rem_u_nxt;
      lock_r  <= lock_nxt;
      held_r  <= held_nxt;
      hkey_r  <= hkey_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ----- rtl/keypad_countdown_timer.sv -----
// Top level of the keypad countdown timer: configuration registers, input
// stage, update engine and result register. Uses kct_pkg, kct_in_reg and
// kct_engine.
//
// The timer takes one request per clock cycle while the consumer does not
// stall and returns exactly one result for each. A request waits in the input
// register, then its state update is written to the result register. The input
// register and the result register decouple the channels, so a new request can
// enter an empty input register while a finished result waits for the consumer.
// Configuration writes are accepted in every cycle and should be made while the timer is idle.
module keypad_countdown_timer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  kct_pkg::in_req_t               in_req,
  output logic                           in_stall,
  output logic                           out_valid,
  output kct_pkg::out_res_t              out_result,
  input  logic                           out_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kct_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [kct_pkg::CntW-1:0]       cfg_data
);

  kct_pkg::cfg_regs_t cfg_r;
  logic               out_valid_r;
  kct_pkg::out_res_t  out_result_r;
  logic               s1_valid;
  kct_pkg::in_req_t   s1_req;
  logic               advance;
  logic               fire;
  kct_pkg::out_res_t  result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_ticks    <= kct_pkg::LOCKOUT_RESET;
      cfg_r.ticks_per_second <= kct_pkg::TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kct_pkg::CFG_LOCKOUT: cfg_r.lockout_ticks    <= cfg_data;
        default:              cfg_r.ticks_per_second <= cfg_data;
      endcase
    end
  end

  kct_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_req   (in_req),
    .in_stall (in_stall),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  kct_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .req    (s1_req),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the keypad countdown timer: sends key and tick requests under
// random gaps and stalls and checks every result against its own prediction.
// Depends on kct_pkg and keypad_countdown_timer.
module testbench;
  import kct_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  class countdown_tracker;
    logic [CntW-1:0]   lockout_ticks;
    logic [CntW-1:0]   ticks_per_second;
    logic [1:0]        mode;
    logic [DigitW-1:0] entry [3];
    logic [DigitW-1:0] remain [3];
    logic [CntW-1:0]   lockout_count;
    logic [CntW-1:0]   second_phase;
    logic              held_valid;
    logic [DigitW-1:0] held_key;
    out_res_t          pending_displays [$];
    int                mismatches;

    function new();
      lockout_ticks = LOCKOUT_RESET;
      ticks_per_second = TPS_RESET;
      mode = MODE_INPUT;
      foreach (entry[i]) begin
        entry[i] = '0;
        remain[i] = '0;
      end
      lockout_count = '0;
      second_phase = '0;
      held_valid = 1'b0;
      held_key = '0;
      mismatches = 0;
    endfunction

    function logic [DigitW-1:0] key_code(logic [KeyW-1:0] col, logic [KeyW-1:0] row);
      string  keys;
      byte    c;
      logic [DigitW-1:0] k;
      case (col)
        2'd0: keys = "dcba";
        2'd1: keys = "#963";
        2'd2: keys = "0852";
        default: keys = "*741";
      endcase
      c = keys[row];
      case (c)
        "a": k = K_A;
        "b": k = K_B;
        "c": k = K_C;
        "d": k = K_D;
        "*": k = K_STAR;
        "#": k = K_HASH;
        default: k = DigitW'(c - "0");
      endcase
      return k;
    endfunction

    function void note_register(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] value);
      if (idx == CFG_LOCKOUT) lockout_ticks = value;
      else ticks_per_second = value;
    endfunction

    function void launch();
      mode = MODE_COUNT;
      foreach (entry[i]) remain[i] = entry[i];
      second_phase = '0;
    endfunction

    function void press_action(logic [DigitW-1:0] k);
      case (mode)
        MODE_INPUT: begin
          if (k <= DIGIT_MAX) begin
            entry[0] = entry[1];
            entry[1] = entry[2];
            entry[2] = k;
            if (entry[0] == DIGIT_MAX && entry[1] > TENS_MAX) begin
              entry[1] = TENS_MAX;
              entry[2] = DIGIT_MAX;
            end
          end else if (k == K_A) begin
            launch();
          end
        end
        MODE_COUNT: begin
          if (k == K_B) mode = MODE_STOP;
        end
        MODE_STOP: begin
          if (k == K_A) launch();
          else if (k == K_D) mode = MODE_INPUT;
        end
        default: begin
          if (k == K_A) launch();
          else if (k == K_B) mode = MODE_STOP;
          else if (k == K_D) mode = MODE_INPUT;
        end
      endcase
    endfunction

    function void count_second();
      if (remain[2] != '0) begin
        remain[2] = remain[2] - DigitW'(1);
      end else if (remain[1] != '0) begin
        remain[1] = remain[1] - DigitW'(1);
        remain[2] = DIGIT_MAX;
      end else if (remain[0] != '0) begin
        remain[0] = remain[0] - DigitW'(1);
        remain[1] = TENS_MAX;
        remain[2] = DIGIT_MAX;
      end else begin
        mode = MODE_ALARM;
      end
    endfunction

    function void note_request(in_req_t req);
      logic [DigitW-1:0] k;
      logic              refresh;
      out_res_t          res;
      k = key_code(req.key_column, req.key_row);
      refresh = 1'b0;
      case (req.opcode)
        OP_PRESS: begin
          if (lockout_count == '0 && !held_valid) begin
            held_valid = 1'b1;
            held_key = k;
            lockout_count = lockout_ticks;
            refresh = 1'b1;
            press_action(k);
          end
        end
        OP_RELEASE: begin
          if (held_valid && held_key == k) begin
            held_valid = 1'b0;
            held_key = '0;
          end
        end
        OP_TICK: begin
          if (lockout_count != '0) lockout_count = lockout_count - CntW'(1);
          if (mode == MODE_COUNT) begin
            if ({1'b0, second_phase} + 11'd1 >= {1'b0, ticks_per_second}) begin
              second_phase = '0;
              refresh = 1'b1;
              count_second();
            end else begin
              second_phase = second_phase + CntW'(1);
            end
          end
        end
        default: ;
      endcase
      res.timer_mode = mode;
      res.entry_minutes = entry[0];
      res.entry_tens = entry[1];
      res.entry_units = entry[2];
      res.remain_minutes = remain[0];
      res.remain_tens = remain[1];
      res.remain_units = remain[2];
      res.key_led = held_valid;
      res.alarm_led = (mode == MODE_ALARM);
      res.refresh = refresh;
      pending_displays.push_back(res);
    endfunction

    function void compare_field(string name, logic [DigitW-1:0] want, logic [DigitW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (pending_displays.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_displays.pop_front();
      compare_field("timer_mode", DigitW'(want.timer_mode), DigitW'(got.timer_mode));
      compare_field("entry_minutes", want.entry_minutes, got.entry_minutes);
      compare_field("entry_tens", want.entry_tens, got.entry_tens);
      compare_field("entry_units", want.entry_units, got.entry_units);
      compare_field("remain_minutes", want.remain_minutes, got.remain_minutes);
      compare_field("remain_tens", want.remain_tens, got.remain_tens);
      compare_field("remain_units", want.remain_units, got.remain_units);
      compare_field("key_led", DigitW'(want.key_led), DigitW'(got.key_led));
      compare_field("alarm_led", DigitW'(want.alarm_led), DigitW'(got.alarm_led));
      compare_field("refresh", DigitW'(want.refresh), DigitW'(got.refresh));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  in_req_t             in_req;
  logic                in_stall;
  logic                out_valid;
  out_res_t            out_result;
  logic                out_stall;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CntW-1:0]     cfg_data;

  countdown_tracker tracker;
  bit               gaps_on;
  bit               stalls_on;
  int               requests_sent;

  keypad_countdown_timer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req     (in_req),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_result (out_result),
    .out_stall  (out_stall),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_result);
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [KeyW-1:0] col,
                           input logic [KeyW-1:0] row);
    in_req_t req;
    req.opcode = op;
    req.key_column = col;
    req.key_row = row;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_stall);
    tracker.note_request(req);
    requests_sent++;
  endtask

  task automatic tick();
    send_item(OP_TICK, KeyW'($urandom_range(0, 3)), KeyW'($urandom_range(0, 3)));
  endtask

  task automatic key_event(input logic [1:0] op, input logic [DigitW-1:0] k);
    int pos;
    pos = 0;
    while (tracker.key_code(KeyW'(pos / 4), KeyW'(pos % 4)) != k) pos++;
    send_item(op, KeyW'(pos / 4), KeyW'(pos % 4));
  endtask

  task automatic click(input logic [DigitW-1:0] k);
    key_event(OP_PRESS, k);
    key_event(OP_RELEASE, k);
  endtask

  // A short lockout is waited out with ticks; a long one lets the press bounce off.
  task automatic tap_key(input logic [DigitW-1:0] k);
    if (tracker.held_valid) key_event(OP_RELEASE, tracker.held_key);
    if (tracker.lockout_count <= CntW'(30)) repeat (int'(tracker.lockout_count)) tick();
    key_event(OP_PRESS, k);
    repeat ($urandom_range(0, 2)) tick();
    if ($urandom_range(0, 9) != 0) key_event(OP_RELEASE, k);
  endtask

  task automatic set_timer(input logic [DigitW-1:0] minutes, input logic [DigitW-1:0] tens,
                           input logic [DigitW-1:0] units);
    if (tracker.mode == MODE_COUNT) tap_key(K_B);
    if (tracker.mode != MODE_INPUT) tap_key(K_D);
    tap_key(minutes);
    tap_key(tens);
    tap_key(units);
    tap_key(K_A);
  endtask

  function automatic logic [DigitW-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return DigitW'($urandom_range(0, 9));
    if (roll < 68) return K_A;
    if (roll < 80) return K_B;
    if (roll < 90) return K_D;
    if (roll < 94) return K_C;
    if (roll < 97) return K_STAR;
    return K_HASH;
  endfunction

  task automatic random_traffic(input int count);
    int target;
    int roll;
    target = requests_sent + count;
    while (requests_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        tap_key(pick_key());
      end else if (roll < 63) begin
        set_timer('0, DigitW'($urandom_range(0, 1)), DigitW'($urandom_range(0, 9)));
      end else if (roll < 88) begin
        repeat ($urandom_range(1, 12)) tick();
      end else begin
        send_item(2'($urandom_range(0, 3)), KeyW'($urandom_range(0, 3)),
                  KeyW'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CntW-1:0] lockout, input logic [CntW-1:0] tps);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LOCKOUT;
    cfg_data <= lockout;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_register(CFG_LOCKOUT, lockout);
    cfg_index <= CFG_TPS;
    cfg_data <= tps;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_register(CFG_TPS, tps);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CntW-1:0] lockout, input logic [CntW-1:0] tps,
                           input int count);
    wait_idle();
    load_settings(lockout, tps);
    random_traffic(count);
  endtask

  initial begin
    tracker = new();
    requests_sent = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LOCKOUT;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start from the reset entry of 0:00, then walk through the modes and the clamp.
    load_settings('0, CntW'(2));
    send_item(OP_UNUSED, 2'd3, 2'd3);
    key_event(OP_RELEASE, DigitW'(1));
    click(K_A);
    tick();
    tick();
    click(K_C);
    click(K_D);
    key_event(OP_PRESS, DigitW'(9));
    key_event(OP_PRESS, DigitW'(4));
    key_event(OP_RELEASE, DigitW'(9));
    click(DigitW'(7));
    click(DigitW'(8));
    click(K_A);
    click(K_B);

    run_phase(CntW'(3), CntW'(1), 300);
    run_phase('0, '0, 250);
    run_phase(CntW'(7), CntW'(7), 400);
    // Leave a long countdown running with a partial second so the next, shorter
    // second length starts below the phase already counted.
    set_timer(DIGIT_MAX, DIGIT_MAX, DIGIT_MAX);
    while (tracker.mode == MODE_COUNT && tracker.second_phase < CntW'(4)) tick();
    run_phase(CntW'(2), CntW'(3), 400);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_phase(CntW'(1), CntW'(1), 200);
    run_phase(CntW'(1023), CntW'(1023), 100);
    wait_idle();

    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
